[rtl/sat_pkg.sv]
// Shared types, constants and codes for the section address translator.
package sat_pkg;

  // Table geometry
  localparam int MAX_SECTIONS = 64;
  localparam int SEC_IDX_W    = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  // Field widths
  localparam int ADDR_W     = 32;
  localparam int OP_W       = 2;
  localparam int IDX_FLD_W  = 6;
  localparam int COUNT_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_FWD  = 2'd1,
    OP_REV  = 2'd2,
    OP_NONE = 2'd3
  } op_e_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_SIZE    = 2'd0,
    CFG_HEADER_SIZE   = 2'd1,
    CFG_FILE_LENGTH   = 2'd2,
    CFG_SECTION_COUNT = 2'd3
  } cfg_idx_e_t;

  // Table write port
  typedef struct packed {
    logic                 en;
    logic [SEC_IDX_W-1:0] idx;
    logic [ADDR_W-1:0]    mbase;
    logic [ADDR_W-1:0]    fbase;
  } sat_wr_t;

  // Compare lane query
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic               fwd;
    logic [COUNT_W-1:0] count;
  } sat_cmp_t;

  // Select query: cut marks lanes where the scan stops
  typedef struct packed {
    logic [MAX_SECTIONS-1:0] cut;
    logic                    fwd;
  } sat_sel_t;

  // Select response
  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
  } sat_rsp_t;

endpackage

[rtl/sat_if.sv]
// Channel interfaces for lookup requests, results and configuration writes.
interface sat_in_if import sat_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [IDX_FLD_W-1:0] section_index;
  logic [ADDR_W-1:0]    memory_base;
  logic [ADDR_W-1:0]    file_base;
  logic [ADDR_W-1:0]    address_in;

  modport source (output valid, operation, section_index, memory_base, file_base,
                  address_in, input ready);
  modport sink (input valid, operation, section_index, memory_base, file_base,
                address_in, output ready);
endinterface

interface sat_out_if import sat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [ADDR_W-1:0] address_out;
  logic              passed_through;

  modport source (output valid, ok, address_out, passed_through, input ready);
  modport sink (input valid, ok, address_out, passed_through, output ready);
endinterface

interface sat_cfg_if import sat_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/sat_section_table.sv]
// Section table: base registers, per-lane compares and one-hot entry select.
module sat_section_table import sat_pkg::*; (
  input  logic     clk,
  input  sat_wr_t  wr,
  input  sat_cmp_t cmp,
  output logic [MAX_SECTIONS-1:0] cut,
  input  sat_sel_t sel_q,
  output sat_rsp_t rsp
);

  logic [ADDR_W-1:0] mem_base_r [MAX_SECTIONS];
  logic [ADDR_W-1:0] file_base_r [MAX_SECTIONS];
  logic [MAX_SECTIONS-1:0] sel;

  // Write one entry per load request
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_base_r[wr.idx]  <= wr.mbase;
      file_base_r[wr.idx] <= wr.fbase;
    end
  end

  // Mark lanes where the scan stops: beyond the count or base above the address
  always_comb begin
    for (int j = 0; j < MAX_SECTIONS; j++) begin
      cut[j] = !((32'(j) < 32'(cmp.count)) &&
                 ((cmp.fwd ? mem_base_r[SEC_IDX_W'(j)] : file_base_r[SEC_IDX_W'(j)])
                  <= cmp.addr));
    end
  end

  // Pick the last lane before the first stop
  for (genvar j = 0; j < MAX_SECTIONS; j++) begin : g_sel
    localparam logic [MAX_SECTIONS-1:0] LOW_MASK =
      {MAX_SECTIONS{1'b1}} >> (MAX_SECTIONS - 1 - j);
    if (j == MAX_SECTIONS - 1) begin : g_last
      assign sel[j] = ~|(sel_q.cut & LOW_MASK);
    end else begin : g_mid
      assign sel[j] = ~|(sel_q.cut & LOW_MASK) & sel_q.cut[j+1];
    end
  end

  // Gather source and destination bases of the selected lane
  always_comb begin
    rsp.hit = !sel_q.cut[0];
    rsp.src = '0;
    rsp.dst = '0;
    for (int j = 0; j < MAX_SECTIONS; j++) begin
      rsp.src = rsp.src | ({ADDR_W{sel[j]}} &
                           (sel_q.fwd ? mem_base_r[SEC_IDX_W'(j)]
                                      : file_base_r[SEC_IDX_W'(j)]));
      rsp.dst = rsp.dst | ({ADDR_W{sel[j]}} &
                           (sel_q.fwd ? file_base_r[SEC_IDX_W'(j)]
                                      : mem_base_r[SEC_IDX_W'(j)]));
    end
  end

endmodule

[rtl/section_address_translator.sv]
// Top level of the section address translator: config, pipeline and result register.
//
//   channel  | dir | handshake     | carries
//   ---------+-----+---------------+-------------------------------------------------
//   in_req   | in  | valid / ready | operation, section_index, bases, address_in
//   out_rsp  | out | valid / ready | ok, address_out, passed_through
//   cfg_req  | in  | valid / ready | index, data (ready is always high)
//
// Four register stages (compare, select, rebase, result); one request can enter
// every cycle while the result is not stalled and no load waits on a lookup.
// A load waits while a lookup is in the compare stage, or a rebasing lookup in the
// select stage, since those stages read the section table; it then writes the table
// when accepted. Reset clears the config registers and the stage valid bits; the
// table is not cleared. A stalled result freezes every stage, nothing is dropped.
module section_address_translator import sat_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  sat_in_if.sink    in_req,
  sat_out_if.source out_rsp,
  sat_cfg_if.sink   cfg_req
);

  // Config registers
  logic [ADDR_W-1:0]  image_size_r;
  logic [ADDR_W-1:0]  header_size_r;
  logic [ADDR_W-1:0]  file_length_r;
  logic [COUNT_W-1:0] section_count_r;

  // Stage A: compare
  logic              a_valid_r;
  op_e_t             a_op_r;
  logic              a_load_ok_r;
  logic [ADDR_W-1:0] a_addr_r;

  // Stage B: select
  logic                    b_valid_r;
  logic                    b_rebase_r;
  logic                    b_fwd_r;
  logic                    b_ok_r;
  logic                    b_pass_r;
  logic [ADDR_W-1:0]       b_addr_r;
  logic [MAX_SECTIONS-1:0] b_cut_r;

  // Stage C: rebase
  logic              c_valid_r;
  logic              c_rebase_r;
  logic              c_hit_r;
  logic              c_ok_r;
  logic              c_pass_r;
  logic [ADDR_W-1:0] c_addr_r;
  logic [ADDR_W-1:0] c_src_r;
  logic [ADDR_W-1:0] c_dst_r;

  // Result register
  logic              out_valid_r;
  logic              out_ok_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic              out_pass_r;

  logic                    advance;
  logic                    in_load;
  logic                    load_block;
  logic                    in_fire;
  logic                    in_idx_ok;
  op_e_t                   in_op;
  logic                    a_fwd;
  logic                    a_lookup;
  logic                    a_in_bound;
  logic                    a_header;
  logic [MAX_SECTIONS-1:0] a_cut;
  logic [ADDR_W-1:0]       c_sum;
  sat_wr_t                 tbl_wr;
  sat_cmp_t                tbl_cmp;
  sat_sel_t                tbl_sel;
  sat_rsp_t                tbl_rsp;

  // Accept configuration writes at any time
  assign cfg_req.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r    <= '0;
      header_size_r   <= '0;
      file_length_r   <= '0;
      section_count_r <= '0;
    end else if (cfg_req.valid) begin
      unique case (cfg_idx_e_t'(cfg_req.index))
        CFG_IMAGE_SIZE:    image_size_r    <= cfg_req.data;
        CFG_HEADER_SIZE:   header_size_r   <= cfg_req.data;
        CFG_FILE_LENGTH:   file_length_r   <= cfg_req.data;
        CFG_SECTION_COUNT: section_count_r <= cfg_req.data[COUNT_W-1:0];
        default:           ;
      endcase
    end
  end

  // Move all stages together whenever the result register can take a new value
  assign advance    = !out_valid_r || out_rsp.ready;
  assign in_op      = op_e_t'(in_req.operation);
  assign in_load    = (in_op == OP_LOAD);
  assign load_block = in_load &&
                      ((a_valid_r && ((a_op_r == OP_FWD) || (a_op_r == OP_REV))) ||
                       (b_valid_r && b_rebase_r));
  assign in_req.ready = advance && !load_block;
  assign in_fire      = in_req.valid && in_req.ready;
  assign in_idx_ok    = (32'(in_req.section_index) < 32'(MAX_SECTIONS));

  // Write the table on an accepted load
  assign tbl_wr.en    = in_fire && in_load && in_idx_ok;
  assign tbl_wr.idx   = SEC_IDX_W'(in_req.section_index);
  assign tbl_wr.mbase = in_req.memory_base;
  assign tbl_wr.fbase = in_req.file_base;

  // Register the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (advance) begin
      a_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_op_r      <= in_op;
      a_load_ok_r <= in_idx_ok;
      a_addr_r    <= in_req.address_in;
    end
  end

  // Stage A: range and header checks, lane compares
  assign a_fwd      = (a_op_r == OP_FWD);
  assign a_lookup   = (a_op_r == OP_FWD) || (a_op_r == OP_REV);
  assign a_in_bound = a_addr_r <= (a_fwd ? image_size_r : file_length_r);
  assign a_header   = a_addr_r < header_size_r;

  assign tbl_cmp.addr  = a_addr_r;
  assign tbl_cmp.fwd   = a_fwd;
  assign tbl_cmp.count = section_count_r;

  sat_section_table u_table (
    .clk   (clk),
    .wr    (tbl_wr),
    .cmp   (tbl_cmp),
    .cut   (a_cut),
    .sel_q (tbl_sel),
    .rsp   (tbl_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (advance) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_rebase_r <= a_lookup && a_in_bound && !a_header;
      b_fwd_r    <= a_fwd;
      b_ok_r     <= ((a_op_r == OP_LOAD) && a_load_ok_r) ||
                    (a_lookup && a_in_bound && a_header);
      b_pass_r   <= a_lookup && a_in_bound && a_header;
      b_addr_r   <= a_addr_r;
      b_cut_r    <= a_cut;
    end
  end

  // Stage B: select the rebasing entry
  assign tbl_sel.cut = b_cut_r;
  assign tbl_sel.fwd = b_fwd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (advance) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c_rebase_r <= b_rebase_r;
      c_hit_r    <= tbl_rsp.hit;
      c_ok_r     <= b_ok_r;
      c_pass_r   <= b_pass_r;
      c_addr_r   <= b_addr_r;
      c_src_r    <= tbl_rsp.src;
      c_dst_r    <= tbl_rsp.dst;
    end
  end

  // Stage C: rebase and form the result
  assign c_sum = c_addr_r - c_src_r + c_dst_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ok_r   <= c_ok_r || (c_rebase_r && c_hit_r);
      out_pass_r <= c_pass_r;
      priority if (c_pass_r) begin
        out_addr_r <= c_addr_r;
      end else if (c_rebase_r && c_hit_r) begin
        out_addr_r <= c_sum;
      end else begin
        out_addr_r <= '0;
      end
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.ok             = out_ok_r;
  assign out_rsp.address_out    = out_addr_r;
  assign out_rsp.passed_through = out_pass_r;

endmodule

[rtl/sat_checker.sv]
// Port-level assertions for the section address translator, bound to the top level.
module sat_checker import sat_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_ok,
  input logic [ADDR_W-1:0] out_address,
  input logic              out_passed
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_address) && $stable(out_ok))
    else $error("stalled result changed or dropped");

  // Failed requests report a zero address and no pass-through
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_address == '0 && !out_passed)
    else $error("failed request with nonzero address or pass flag");

  // A header pass-through is always a success
  a_pass_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_passed |-> out_ok)
    else $error("pass-through without ok");

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind section_address_translator sat_checker u_sat_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_rsp.valid),
  .out_ready   (out_rsp.ready),
  .out_ok      (out_rsp.ok),
  .out_address (out_rsp.address_out),
  .out_passed  (out_rsp.passed_through)
);

[tb/section_address_translator_tb.sv]
// Self-checking testbench for the section address translator.
module section_address_translator_tb;
  import sat_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    op_e_t                op;
    logic [IDX_FLD_W-1:0] idx;
    logic [ADDR_W-1:0]    mbase;
    logic [ADDR_W-1:0]    fbase;
    logic [ADDR_W-1:0]    addr;
  } xlat_req_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] addr;
    logic              pass;
  } xlat_rsp_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_CHOPPY, RX_LONG} rx_mode_e_t;

  logic clk;
  logic rst_n;

  sat_in_if  in_req ();
  sat_out_if out_rsp ();
  sat_cfg_if cfg_req ();

  section_address_translator u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cfg_req (cfg_req)
  );

  // Mirror of the block's registers and section table
  logic [ADDR_W-1:0]  img_size_r;
  logic [ADDR_W-1:0]  hdr_size_r;
  logic [ADDR_W-1:0]  file_len_r;
  logic [COUNT_W-1:0] sec_count_r;
  logic [ADDR_W-1:0]  tbl_mb [MAX_SECTIONS];
  logic [ADDR_W-1:0]  tbl_fb [MAX_SECTIONS];

  // Table layout as seen by the stimulus generator
  logic [ADDR_W-1:0]  gen_mb [MAX_SECTIONS];
  logic [ADDR_W-1:0]  gen_fb [MAX_SECTIONS];

  xlat_req_t req_backlog_q [$];
  xlat_rsp_t xlat_due_q [$];
  int        n_pushed;
  int        n_done;
  int        err_count;
  bit        in_taken;

  int         burst_left;
  int         gap_left;
  rx_mode_e_t rx_mode;
  int         mode_left;
  int         stall_left;

  always #5 clk = ~clk;

  // Translate one request and update the table mirror on loads
  function automatic xlat_rsp_t predict_translation(xlat_req_t r);
    xlat_rsp_t   p;
    logic [ADDR_W-1:0] bound;
    int unsigned lim;
    int unsigned k;
    bit          fwd;
    p   = '0;
    fwd = (r.op == OP_FWD);
    case (r.op)
      OP_LOAD: begin
        if (r.idx < MAX_SECTIONS) begin
          tbl_mb[r.idx] = r.mbase;
          tbl_fb[r.idx] = r.fbase;
          p.ok = 1'b1;
        end
      end
      OP_FWD, OP_REV: begin
        bound = fwd ? img_size_r : file_len_r;
        if (r.addr <= bound) begin
          if (r.addr < hdr_size_r) begin
            p.ok   = 1'b1;
            p.addr = r.addr;
            p.pass = 1'b1;
          end else begin
            lim = (sec_count_r > MAX_SECTIONS) ? MAX_SECTIONS : sec_count_r;
            k   = 0;
            // stop at the first section that starts above the address
            while (k < lim &&
                   ((fwd ? tbl_mb[SEC_IDX_W'(k)] : tbl_fb[SEC_IDX_W'(k)]) <= r.addr))
              k++;
            if (k > 0) begin
              p.ok   = 1'b1;
              p.addr = fwd ? r.addr - tbl_mb[SEC_IDX_W'(k - 1)] + tbl_fb[SEC_IDX_W'(k - 1)]
                           : r.addr - tbl_fb[SEC_IDX_W'(k - 1)] + tbl_mb[SEC_IDX_W'(k - 1)];
            end
          end
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  // Predict each request at the edge that accepts it
  always @(posedge clk) begin : accept_blk
    xlat_req_t r;
    if (rst_n && in_req.valid && in_req.ready) begin
      r.op    = op_e_t'(in_req.operation);
      r.idx   = in_req.section_index;
      r.mbase = in_req.memory_base;
      r.fbase = in_req.file_base;
      r.addr  = in_req.address_in;
      xlat_due_q.insert(xlat_due_q.size(), predict_translation(r));
      in_taken = 1'b1;
    end
  end

  // Drive requests in bursts separated by random gaps
  always @(negedge clk) begin : drive_blk
    xlat_req_t nxt;
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else if (!in_req.valid || in_taken) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_req.valid <= 1'b0;
      end else if (req_backlog_q.size() > 0) begin
        nxt = req_backlog_q.pop_front();
        in_req.operation     <= nxt.op;
        in_req.section_index <= nxt.idx;
        in_req.memory_base   <= nxt.mbase;
        in_req.file_base     <= nxt.fbase;
        in_req.address_in    <= nxt.addr;
        in_req.valid         <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          case ($urandom_range(0, 9))
            0, 1, 2: gap_left = 0;
            3:       gap_left = $urandom_range(10, 30);
            default: gap_left = $urandom_range(1, 8);
          endcase
        end
      end else begin
        in_req.valid <= 1'b0;
      end
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin : check_blk
    xlat_rsp_t w;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (xlat_due_q.size() == 0) begin
        err_count++;
        $display("%0t: result with no request outstanding, actual ok=%0b addr=%h pass=%0b",
                 $realtime, out_rsp.ok, out_rsp.address_out, out_rsp.passed_through);
      end else begin
        w = xlat_due_q.pop_front();
        n_done++;
        if (out_rsp.ok !== w.ok) begin
          err_count++;
          $display("%0t: ok mismatch, expected %0b actual %0b", $realtime, w.ok, out_rsp.ok);
        end
        if (out_rsp.address_out !== w.addr) begin
          err_count++;
          $display("%0t: address_out mismatch, expected %h actual %h",
                   $realtime, w.addr, out_rsp.address_out);
        end
        if (out_rsp.passed_through !== w.pass) begin
          err_count++;
          $display("%0t: passed_through mismatch, expected %0b actual %0b",
                   $realtime, w.pass, out_rsp.passed_through);
        end
      end
    end
  end

  // Stall the result channel on a pattern that changes now and then
  always @(negedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e_t'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_rsp.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:   out_rsp.ready <= 1'b1;
          RX_LIGHT: begin
            if ($urandom_range(0, 3) == 0) begin
              stall_left = $urandom_range(0, 3);
              out_rsp.ready <= 1'b0;
            end else begin
              out_rsp.ready <= 1'b1;
            end
          end
          RX_CHOPPY: out_rsp.ready <= 1'($urandom_range(0, 1));
          default: begin
            if ($urandom_range(0, 7) == 0) begin
              stall_left = $urandom_range(5, 30);
              out_rsp.ready <= 1'b0;
            end else begin
              out_rsp.ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Queue one request and track the table layout it produces
  task automatic push_req(op_e_t op, logic [IDX_FLD_W-1:0] idx,
                          logic [ADDR_W-1:0] mb, logic [ADDR_W-1:0] fb,
                          logic [ADDR_W-1:0] a);
    xlat_req_t r;
    r = '{op, idx, mb, fb, a};
    if (op == OP_LOAD) begin
      gen_mb[idx] = mb;
      gen_fb[idx] = fb;
    end
    req_backlog_q.insert(req_backlog_q.size(), r);
    n_pushed++;
  endtask

  // Hold until every queued request has its result, then let the pipe settle
  task automatic wait_drained();
    do @(negedge clk); while (n_done != n_pushed);
    repeat (8) @(negedge clk);
  endtask

  // Write one register and mirror it once accepted
  task automatic cfg_write(cfg_idx_e_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_req.valid <= 1'b1;
    cfg_req.index <= idx;
    cfg_req.data  <= val;
    do @(posedge clk); while (!cfg_req.ready);
    case (idx)
      CFG_IMAGE_SIZE:    img_size_r  = val;
      CFG_HEADER_SIZE:   hdr_size_r  = val;
      CFG_FILE_LENGTH:   file_len_r  = val;
      CFG_SECTION_COUNT: sec_count_r = val[COUNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_req.valid <= 1'b0;
  endtask

  task automatic apply_cfg(logic [ADDR_W-1:0] img, logic [ADDR_W-1:0] hdr,
                           logic [ADDR_W-1:0] flen, logic [CFG_DATA_W-1:0] cnt);
    wait_drained();
    cfg_write(CFG_IMAGE_SIZE, img);
    cfg_write(CFG_HEADER_SIZE, hdr);
    cfg_write(CFG_FILE_LENGTH, flen);
    cfg_write(CFG_SECTION_COUNT, cnt);
  endtask

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : stim
    int                unsigned cnt;
    int                unsigned n;
    int                unsigned k;
    int                num;
    int                rand_items;
    bit                unordered;
    op_e_t             op;
    logic [ADDR_W-1:0] hdr;
    logic [ADDR_W-1:0] img;
    logic [ADDR_W-1:0] flen;
    logic [ADDR_W-1:0] mb;
    logic [ADDR_W-1:0] fb;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] bound;
    logic [ADDR_W-1:0] a;

    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_req.valid         = 1'b0;
    in_req.operation     = OP_LOAD;
    in_req.section_index = '0;
    in_req.memory_base   = '0;
    in_req.file_base     = '0;
    in_req.address_in    = '0;
    out_rsp.ready        = 1'b0;
    cfg_req.valid        = 1'b0;
    cfg_req.index        = CFG_IMAGE_SIZE;
    cfg_req.data         = '0;
    img_size_r           = '0;
    hdr_size_r           = '0;
    file_len_r           = '0;
    sec_count_r          = '0;
    n_pushed             = 0;
    n_done               = 0;
    err_count            = 0;
    in_taken             = 1'b0;
    burst_left           = 0;
    gap_left             = 0;
    rx_mode              = RX_FREE;
    mode_left            = 0;
    stall_left           = 0;
    rand_items           = 0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: empty table, zero bounds
    push_req(OP_FWD, '0, '0, '0, 32'h0);
    push_req(OP_FWD, '1, '1, '1, 32'hFFFF_FFFF);
    push_req(OP_REV, '0, '0, '0, 32'h0);
    push_req(OP_NONE, '1, '1, '1, 32'hFFFF_FFFF);
    push_req(OP_LOAD, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(OP_LOAD, 6'd0, 32'h0, 32'h0, 32'h0);

    // Two sections, header region, full-range bounds
    apply_cfg(32'hFFFF_FFFF, 32'h400, 32'hFFFF_FFFF, 32'hFFFF_FF82);
    push_req(OP_LOAD, 6'd0, 32'h1000, 32'h400, '0);
    push_req(OP_LOAD, 6'd1, 32'h3000, 32'h2400, '0);
    push_req(OP_FWD, '0, '0, '0, 32'h3FF);
    push_req(OP_FWD, '0, '0, '0, 32'h400);
    push_req(OP_FWD, '0, '0, '0, 32'h1000);
    push_req(OP_FWD, '0, '0, '0, 32'h2FFF);
    push_req(OP_FWD, '0, '0, '0, 32'h3000);
    push_req(OP_FWD, '0, '0, '0, 32'hFFFF_FFFF);
    push_req(OP_REV, '0, '0, '0, 32'h3FF);
    push_req(OP_REV, '0, '0, '0, 32'h400);
    push_req(OP_REV, '0, '0, '0, 32'h23FF);
    push_req(OP_REV, '0, '0, '0, 32'hFFFF_FFFF);
    push_req(OP_NONE, '0, '0, '0, '0);

    // Bounds below the header: range check wins
    apply_cfg(32'h200, 32'h400, 32'h0, 32'h2);
    push_req(OP_FWD, '0, '0, '0, 32'h300);
    push_req(OP_FWD, '0, '0, '0, 32'h200);
    push_req(OP_REV, '0, '0, '0, 32'h1);
    push_req(OP_REV, '0, '0, '0, 32'h0);

    // Random phases: new layout, reload the table, then mostly lookups
    while (rand_items < 1200) begin
      case ($urandom_range(0, 9))
        0:       cnt = 0;
        1:       cnt = $urandom_range(64, 127);
        default: cnt = $urandom_range(1, 8);
      endcase
      n         = (cnt > MAX_SECTIONS) ? MAX_SECTIONS : cnt;
      unordered = ($urandom_range(0, 6) == 0);
      case ($urandom_range(0, 5))
        0:       hdr = 32'h0;
        1:       hdr = 32'hFFFF_FFFF;
        default: hdr = $urandom_range(0, 32'h1000);
      endcase
      if ($urandom_range(0, 4) == 0) begin
        mb = $urandom;
        fb = $urandom;
      end else begin
        mb = hdr + $urandom_range(0, 32'h800);
        fb = $urandom_range(0, 32'h800) + ($urandom_range(0, 1) ? hdr : 32'h0);
      end
      for (k = 0; k < n; k++) begin
        if (unordered) begin
          gen_mb[SEC_IDX_W'(k)] = $urandom;
          gen_fb[SEC_IDX_W'(k)] = $urandom;
        end else begin
          gen_mb[SEC_IDX_W'(k)] = mb;
          gen_fb[SEC_IDX_W'(k)] = fb;
          mb += $urandom_range(0, 32'h4000);
          fb += $urandom_range(0, 32'h4000);
        end
      end
      case ($urandom_range(0, 5))
        0:       img = 32'hFFFF_FFFF;
        1:       img = 32'h0;
        default: img = mb + $urandom_range(0, 32'h2000);
      endcase
      case ($urandom_range(0, 5))
        0:       flen = 32'hFFFF_FFFF;
        1:       flen = 32'h0;
        default: flen = fb + $urandom_range(0, 32'h2000);
      endcase
      apply_cfg(img, hdr, flen, CFG_DATA_W'({$urandom, 7'd0} | cnt));

      // Fill every live entry before any lookup can read it
      for (k = 0; k < n; k++)
        push_req(OP_LOAD, IDX_FLD_W'(k), gen_mb[SEC_IDX_W'(k)], gen_fb[SEC_IDX_W'(k)],
                 $urandom);

      num = $urandom_range(40, 100);
      repeat (num) begin
        case ($urandom_range(0, 19))
          0: push_req(OP_LOAD, IDX_FLD_W'($urandom_range(0, MAX_SECTIONS - 1)), $urandom,
                      $urandom, $urandom);
          1: push_req(OP_NONE, IDX_FLD_W'($urandom), $urandom, $urandom, $urandom);
          default: begin
            op    = $urandom_range(0, 1) ? OP_FWD : OP_REV;
            k     = (n > 0) ? $urandom_range(0, n - 1) : 0;
            base  = (op == OP_FWD) ? gen_mb[SEC_IDX_W'(k)] : gen_fb[SEC_IDX_W'(k)];
            bound = (op == OP_FWD) ? img : flen;
            case ($urandom_range(0, 9))
              0:          a = base - 1;
              1:          a = base;
              2, 3, 4, 5: a = base + $urandom_range(0, 32'h3FFF);
              6:          a = hdr - $urandom_range(0, 1);
              7:          a = bound + $urandom_range(0, 1);
              8:          a = $urandom;
              default:    a = $urandom_range(0, 32'h100);
            endcase
            push_req(op, IDX_FLD_W'($urandom), $urandom, $urandom, a);
          end
        endcase
      end
      rand_items += n + num;
    end

    wait_drained();
    if (err_count == 0 && xlat_due_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
